FILE: sv/swts_pkg.sv
// Package for the shortest-window-with-target-sum block.
// Holds shared widths and the step code type of the search sequencer.
// No dependencies.
`timescale 1ns / 1ps

package swts_pkg;

  // Width of the target sum register.
  localparam int unsigned TARGET_W = 26;

  // Width of the start and end indices in a result.
  localparam int unsigned OUT_IDX_W = 10;

  // Result tdata carries start and end, padded to whole bytes.
  localparam int unsigned DATA_OUT_W = ((2 * OUT_IDX_W + 7) / 8) * 8;

  // Memory read that is pending while the sequencer waits for the data.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_FIRST,
    OP_ADD,
    OP_SUB
  } op_e;

endpackage : swts_pkg

FILE: sv/swts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module swts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : swts_ram

FILE: sv/shortest_window_with_target_sum_core.sv
// Top level of the shortest-window-with-target-sum block.
// Depends on swts_pkg and swts_ram.
//
// Usage:
//   The slave stream carries one element per request: tdata holds the value,
//   tlast marks the final element of a sequence. Elements are written into
//   an internal RAM at one per cycle while idle; those beyond MAX_ELEMENTS are
//   dropped, but a request with tlast still closes the sequence.
//   The request with tlast starts a two-pointer scan over the stored run.
//   The scan reads the RAM to fetch the first element, then each step
//   either advances the end pointer and reads the new element, or advances
//   the start pointer and reads the dropped one unless the window is empty.
//   The element RAM has a single read port.
//   The master stream then carries one result request: tuser is the found
//   flag, tdata the start and end indices of the shortest matching window
//   (earliest start on ties), both zero when nothing matched.
//   While the scan runs, s_axis_tready is low. A result waiting on a
//   stalled receiver stays in its output register; loading of the next
//   sequence goes on meanwhile, and only the next scan result waits.
//   Reset empties the sequence and sets the target sum to one; the RAM needs
//   no clearing pass. Write the target (cfg_we_i) only while idle; unenforced.
`timescale 1ns / 1ps

module shortest_window_with_target_sum_core #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned VALUE_BITS   = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Target sum register write.
  input  logic                                    cfg_we_i,
  input  logic [swts_pkg::TARGET_W-1:0]           cfg_wdata_i,
  // Element stream. tdata: value [VALUE_BITS-1:0], zero padded.
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                                    s_axis_tlast,
  // Result stream. tdata: start_index [9:0], end_index [19:10], zero padded.
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [swts_pkg::DATA_OUT_W-1:0]         m_axis_tdata,
  // tuser: found [0].
  output logic                                    m_axis_tuser
);

  import swts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SUM_W = ((TARGET_W > VALUE_BITS) ? TARGET_W : VALUE_BITS) + 1;
  localparam int unsigned EXT_W = ((IDX_W + 1) > OUT_IDX_W) ? (IDX_W + 1) : OUT_IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_OUT
  } state_e;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [TARGET_W-1:0]  target_q, target_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [IDX_W-1:0]     front_q, front_d;
  logic [IDX_W-1:0]     back_q, back_d;
  logic [IDX_W-1:0]     best_start_q, best_start_d;
  logic [IDX_W-1:0]     best_len_q, best_len_d;
  logic                 have_q, have_d;
  logic                 out_valid_q, out_valid_d;
  logic                 res_found_q, res_found_d;
  logic [OUT_IDX_W-1:0] res_start_q, res_start_d;
  logic [OUT_IDX_W-1:0] res_end_q, res_end_d;

  logic                  in_fire;
  logic                  store_we;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic [SUM_W-1:0]      sum_eff;
  logic [SUM_W-1:0]      target_ext;
  logic [IDX_W-1:0]      cur_len;
  logic [IDX_W:0]        end_full;
  logic [EXT_W-1:0]      start_ext;
  logic [EXT_W-1:0]      end_ext;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign store_we = in_fire && (count_q < CNT_W'(MAX_ELEMENTS));

  // Element store.
  swts_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata[VALUE_BITS-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Window sum with the pending memory read folded in.
  always_comb begin
    case (op_q)
      OP_FIRST: sum_eff = SUM_W'(rd_data);
      OP_ADD:   sum_eff = sum_q + SUM_W'(rd_data);
      OP_SUB:   sum_eff = sum_q - SUM_W'(rd_data);
      default:  sum_eff = sum_q;
    endcase
  end

  assign target_ext = SUM_W'(target_q);
  assign cur_len    = back_q - front_q;

  // Result indices, masked to the output width.
  assign end_full  = {1'b0, best_start_q} + {1'b0, best_len_q};
  assign start_ext = EXT_W'(best_start_q);
  assign end_ext   = EXT_W'(end_full);

  // Sequencer: load, start, scan and hand over the result.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    target_d     = target_q;
    count_d      = count_q;
    n_d          = n_q;
    sum_d        = sum_q;
    front_d      = front_q;
    back_d       = back_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    have_d       = have_q;
    out_valid_d  = out_valid_q;
    res_found_d  = res_found_q;
    res_start_d  = res_start_q;
    res_end_d    = res_end_q;
    rd_en        = 1'b0;
    rd_addr      = '0;

    if (cfg_we_i) begin
      target_d = cfg_wdata_i;
    end
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (store_we) begin
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            n_d     = store_we ? (count_q + CNT_W'(1)) : count_q;
            count_d = '0;
            state_d = ST_START;
          end
        end
      end

      ST_START: begin
        // Fetch the first element; the scan starts with both pointers at zero.
        rd_en        = 1'b1;
        rd_addr      = '0;
        op_d         = OP_FIRST;
        front_d      = '0;
        back_d       = '0;
        have_d       = 1'b0;
        best_start_d = '0;
        best_len_d   = '0;
        state_d      = (n_q == '0) ? ST_OUT : ST_RUN;
      end

      ST_RUN: begin
        sum_d = sum_eff;
        if ((sum_eff < target_ext) && ((CNT_W'(back_q) + CNT_W'(1)) < n_q)) begin
          // Grow the window by one element at the end.
          rd_en   = 1'b1;
          rd_addr = back_q + IDX_W'(1);
          back_d  = back_q + IDX_W'(1);
          op_d    = OP_ADD;
        end else begin
          // Record a match, keeping the shortest and earliest.
          if ((sum_eff == target_ext) && (back_q >= front_q)) begin
            if (!have_q || (cur_len < best_len_q)) begin
              have_d       = 1'b1;
              best_len_d   = cur_len;
              best_start_d = front_q;
            end
          end
          // Drop the element at the front, or empty the window.
          if (back_q >= front_q) begin
            rd_en   = 1'b1;
            rd_addr = front_q;
            op_d    = OP_SUB;
          end else begin
            sum_d = '0;
            op_d  = OP_NONE;
          end
          front_d = front_q + IDX_W'(1);
          if ((CNT_W'(front_q) + CNT_W'(1)) == n_q) begin
            state_d = ST_OUT;
          end
        end
      end

      ST_OUT: begin
        // Wait for the output register to be free.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          res_found_d = have_q;
          res_start_d = have_q ? start_ext[OUT_IDX_W-1:0] : '0;
          res_end_d   = have_q ? end_ext[OUT_IDX_W-1:0] : '0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      target_q    <= TARGET_W'(1);
      count_q     <= '0;
      n_q         <= '0;
      sum_q       <= '0;
      front_q     <= '0;
      back_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      target_q    <= target_d;
      count_q     <= count_d;
      n_q         <= n_d;
      sum_q       <= sum_d;
      front_q     <= front_d;
      back_q      <= back_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    res_found_q  <= res_found_d;
    res_start_q  <= res_start_d;
    res_end_q    <= res_end_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_found_q;
  assign m_axis_tdata  = {{(DATA_OUT_W - 2 * OUT_IDX_W){1'b0}}, res_end_q, res_start_q};

endmodule : shortest_window_with_target_sum_core

FILE: sv/swts_checker.sv
// Port-level checks for the shortest-window-with-target-sum block.
// Depends on swts_pkg; bound to shortest_window_with_target_sum_core.
`timescale 1ns / 1ps

module swts_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [swts_pkg::DATA_OUT_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  import swts_pkg::*;

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // A result without a match carries zero indices.
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("no-match result with nonzero indices");

  // The closing element starts the scan, which holds off new elements.
  a_scan_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("element taken right after the closing element");

endmodule : swts_checker

bind shortest_window_with_target_sum_core swts_checker u_swts_checker (.*);
